### rtl/bltf_pkg.sv
// ----------------------------------------------------------------------------
// bltf_pkg
// Shared types and constants for the batch latency table and flush timer.
// ----------------------------------------------------------------------------
package bltf_pkg;

    localparam int TABLE_ENTRIES = 20;
    localparam int LATENCY_BITS  = 48;
    localparam int SENSOR_BITS   = 32;
    localparam int OPCODE_BITS   = 3;
    localparam int IDX_BITS      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_SET     = 3'd0,
        OP_START   = 3'd1,
        OP_STOP    = 3'd2,
        OP_SUSPEND = 3'd3,
        OP_RESUME  = 3'd4,
        OP_TICK    = 3'd5
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SEARCH,
        ST_WRITE,
        ST_MINSCAN,
        ST_FINISH,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic search_step;
        logic write_entry;
        logic min_step;
        logic finish_set;
        logic exec_ctrl;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_set;
        logic scan_last;
        logic no_slot;
        logic out_busy;
    } stat_t;

endpackage

### rtl/batch_latency_table_flush_timer.sv
// ----------------------------------------------------------------------------
// batch_latency_table_flush_timer
// Sensor report latency table with a periodic flush countdown.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries opcode, sensor_id and latency.
//   A set transaction adds, updates or frees a table entry and recomputes the
//   least live latency; start, stop, suspend and resume steer the countdown;
//   a tick transaction decrements it and raises flush when it expires.
//   Output channel (out_valid/out_ready) returns exactly one result per input
//   transaction, in order.
//   One transaction is in work at a time. A control or tick transaction is
//   decoded and executed, then its result is loaded; a set transaction
//   searches the table, writes its entry, then makes a minimum pass, each
//   pass one entry per cycle, before its result is loaded. A set that
//   overflows skips the minimum pass.
//   in_ready is high only while the sequencer idles; the result register lets
//   a new transaction start while the previous result still waits.
//   Reset clears the table (all entries free), sets the least latency to all
//   ones, stops and disarms the countdown and empties the result register.
//   When the receiver stalls, the result holds in place and the next finished
//   transaction waits in the sequencer until the result register frees.
// ----------------------------------------------------------------------------
module batch_latency_table_flush_timer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [bltf_pkg::OPCODE_BITS-1:0]    opcode,
    input  logic [bltf_pkg::SENSOR_BITS-1:0]    sensor_id,
    input  logic [bltf_pkg::LATENCY_BITS-1:0]   latency,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                flush,
    output logic                                running,
    output logic                                timer_armed,
    output logic [bltf_pkg::LATENCY_BITS-1:0]   min_report_latency,
    output logic                                any_live,
    output logic                                overflow_drop
);

    bltf_pkg::cmd_t  cmd;
    bltf_pkg::stat_t stat;

    // Sequencer: walks each transaction through decode and table passes
    bltf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Table, countdown and result register
    bltf_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .opcode             (opcode),
        .sensor_id          (sensor_id),
        .latency            (latency),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .flush              (flush),
        .running            (running),
        .timer_armed        (timer_armed),
        .min_report_latency (min_report_latency),
        .any_live           (any_live),
        .overflow_drop      (overflow_drop)
    );

endmodule

### rtl/bltf_ctrl.sv
// ----------------------------------------------------------------------------
// bltf_ctrl
// Sequencer for one transaction: decode, table search, write, minimum scan.
// ----------------------------------------------------------------------------
module bltf_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  bltf_pkg::stat_t stat,
    output bltf_pkg::cmd_t  cmd
);

    bltf_pkg::state_t state_reg;
    bltf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bltf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            bltf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = bltf_pkg::ST_DECODE;
                end
            end
            bltf_pkg::ST_DECODE:
            begin
                if (stat.is_set)
                begin
                    state_next = bltf_pkg::ST_SEARCH;
                end
                else
                begin
                    cmd.exec_ctrl = 1'b1;
                    state_next    = bltf_pkg::ST_DONE;
                end
            end
            bltf_pkg::ST_SEARCH:
            begin
                cmd.search_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = bltf_pkg::ST_WRITE;
                end
            end
            bltf_pkg::ST_WRITE:
            begin
                cmd.write_entry = 1'b1;
                state_next = stat.no_slot ? bltf_pkg::ST_DONE : bltf_pkg::ST_MINSCAN;
            end
            bltf_pkg::ST_MINSCAN:
            begin
                cmd.min_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = bltf_pkg::ST_FINISH;
                end
            end
            bltf_pkg::ST_FINISH:
            begin
                cmd.finish_set = 1'b1;
                state_next     = bltf_pkg::ST_DONE;
            end
            bltf_pkg::ST_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = bltf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bltf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/bltf_datapath.sv
// ----------------------------------------------------------------------------
// bltf_datapath
// Latency table, minimum accumulator, run/arm flags, countdown, result reg.
// ----------------------------------------------------------------------------
module bltf_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bltf_pkg::cmd_t                      cmd,
    output bltf_pkg::stat_t                     stat,
    input  logic [bltf_pkg::OPCODE_BITS-1:0]    opcode,
    input  logic [bltf_pkg::SENSOR_BITS-1:0]    sensor_id,
    input  logic [bltf_pkg::LATENCY_BITS-1:0]   latency,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                flush,
    output logic                                running,
    output logic                                timer_armed,
    output logic [bltf_pkg::LATENCY_BITS-1:0]   min_report_latency,
    output logic                                any_live,
    output logic                                overflow_drop
);

    localparam logic [bltf_pkg::LATENCY_BITS-1:0] LAT_ONES = '1;
    localparam logic [bltf_pkg::IDX_BITS-1:0] LAST_IDX =
        bltf_pkg::IDX_BITS'(bltf_pkg::TABLE_ENTRIES - 1);

    // Captured transaction
    logic [bltf_pkg::OPCODE_BITS-1:0]  op_reg;
    logic [bltf_pkg::SENSOR_BITS-1:0]  id_reg;
    logic [bltf_pkg::LATENCY_BITS-1:0] lat_reg;

    // Table
    logic [bltf_pkg::SENSOR_BITS-1:0]  sensor_tab_reg  [bltf_pkg::TABLE_ENTRIES];
    logic [bltf_pkg::LATENCY_BITS-1:0] latency_tab_reg [bltf_pkg::TABLE_ENTRIES];

    // Scan state
    logic [bltf_pkg::IDX_BITS-1:0]     scan_idx_reg;
    logic                              hit_found_reg;
    logic [bltf_pkg::IDX_BITS-1:0]     hit_idx_reg;
    logic                              blank_found_reg;
    logic [bltf_pkg::IDX_BITS-1:0]     blank_idx_reg;
    logic [bltf_pkg::LATENCY_BITS-1:0] least_acc_reg;
    logic                              live_acc_reg;

    // Architectural state
    logic [bltf_pkg::LATENCY_BITS-1:0] least_reg;
    logic                              run_reg;
    logic                              armed_reg;
    logic [bltf_pkg::LATENCY_BITS-1:0] ticks_reg;
    logic                              any_live_reg;
    logic                              flush_item_reg;
    logic                              drop_item_reg;

    // Result register
    logic                              out_valid_reg;
    logic                              out_flush_reg;
    logic                              out_run_reg;
    logic                              out_armed_reg;
    logic [bltf_pkg::LATENCY_BITS-1:0] out_least_reg;
    logic                              out_live_reg;
    logic                              out_drop_reg;

    logic [bltf_pkg::SENSOR_BITS-1:0]  cur_sensor;
    logic [bltf_pkg::LATENCY_BITS-1:0] cur_latency;
    logic [bltf_pkg::IDX_BITS-1:0]     target_idx;
    logic                              no_slot;

    assign cur_sensor  = sensor_tab_reg[scan_idx_reg];
    assign cur_latency = latency_tab_reg[scan_idx_reg];
    assign no_slot     = !hit_found_reg && !blank_found_reg;
    assign target_idx  = hit_found_reg ? hit_idx_reg : blank_idx_reg;

    assign stat.is_set    = (op_reg == bltf_pkg::OP_SET);
    assign stat.scan_last = (scan_idx_reg == LAST_IDX);
    assign stat.no_slot   = no_slot;
    assign stat.out_busy  = out_valid_reg && !out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= opcode;
            id_reg  <= sensor_id;
            lat_reg <= latency;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < bltf_pkg::TABLE_ENTRIES; k++)
            begin
                sensor_tab_reg[k]  <= '0;
                latency_tab_reg[k] <= '0;
            end
            scan_idx_reg    <= '0;
            hit_found_reg   <= 1'b0;
            hit_idx_reg     <= '0;
            blank_found_reg <= 1'b0;
            blank_idx_reg   <= '0;
            least_acc_reg   <= LAT_ONES;
            live_acc_reg    <= 1'b0;
            least_reg       <= LAT_ONES;
            run_reg         <= 1'b0;
            armed_reg       <= 1'b0;
            ticks_reg       <= '0;
            any_live_reg    <= 1'b0;
            flush_item_reg  <= 1'b0;
            drop_item_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                scan_idx_reg    <= '0;
                hit_found_reg   <= 1'b0;
                blank_found_reg <= 1'b0;
                flush_item_reg  <= 1'b0;
                drop_item_reg   <= 1'b0;
            end

            // Search pass: last matching entry, first free entry
            if (cmd.search_step)
            begin
                if (cur_sensor == '0)
                begin
                    if (!blank_found_reg)
                    begin
                        blank_found_reg <= 1'b1;
                        blank_idx_reg   <= scan_idx_reg;
                    end
                end
                else if (cur_sensor == id_reg)
                begin
                    hit_found_reg <= 1'b1;
                    hit_idx_reg   <= scan_idx_reg;
                end
                scan_idx_reg <= stat.scan_last ? '0 : scan_idx_reg + 1'b1;
            end

            if (cmd.write_entry)
            begin
                if (no_slot)
                begin
                    drop_item_reg <= 1'b1;
                    run_reg       <= 1'b0;
                    armed_reg     <= 1'b0;
                end
                else if (lat_reg != '0)
                begin
                    sensor_tab_reg[target_idx]  <= id_reg;
                    latency_tab_reg[target_idx] <= lat_reg;
                end
                else
                begin
                    sensor_tab_reg[target_idx]  <= '0;
                    latency_tab_reg[target_idx] <= '0;
                end
                scan_idx_reg  <= '0;
                least_acc_reg <= LAT_ONES;
                live_acc_reg  <= 1'b0;
            end

            // Minimum pass over live entries
            if (cmd.min_step)
            begin
                if (cur_sensor != '0)
                begin
                    live_acc_reg <= 1'b1;
                    if (cur_latency < least_acc_reg)
                    begin
                        least_acc_reg <= cur_latency;
                    end
                end
                scan_idx_reg <= stat.scan_last ? '0 : scan_idx_reg + 1'b1;
            end

            if (cmd.finish_set)
            begin
                least_reg    <= least_acc_reg;
                any_live_reg <= live_acc_reg;
                run_reg      <= live_acc_reg;
                armed_reg    <= live_acc_reg;
                if (live_acc_reg)
                begin
                    ticks_reg <= least_acc_reg;
                end
            end

            if (cmd.exec_ctrl)
            begin
                unique case (op_reg)
                    bltf_pkg::OP_START:
                    begin
                        if (!run_reg)
                        begin
                            run_reg   <= 1'b1;
                            armed_reg <= 1'b1;
                            ticks_reg <= least_reg;
                        end
                    end
                    bltf_pkg::OP_STOP:
                    begin
                        run_reg   <= 1'b0;
                        armed_reg <= 1'b0;
                    end
                    bltf_pkg::OP_SUSPEND:
                    begin
                        armed_reg <= 1'b0;
                    end
                    bltf_pkg::OP_RESUME:
                    begin
                        if (run_reg)
                        begin
                            armed_reg <= 1'b1;
                            ticks_reg <= least_reg;
                        end
                    end
                    bltf_pkg::OP_TICK:
                    begin
                        if (armed_reg)
                        begin
                            if (ticks_reg <= bltf_pkg::LATENCY_BITS'(1))
                            begin
                                flush_item_reg <= 1'b1;
                                ticks_reg      <= least_reg;
                            end
                            else
                            begin
                                ticks_reg <= ticks_reg - 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Result register: valid control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register: payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_flush_reg <= flush_item_reg;
            out_run_reg   <= run_reg;
            out_armed_reg <= armed_reg;
            out_least_reg <= least_reg;
            out_live_reg  <= any_live_reg;
            out_drop_reg  <= drop_item_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign flush              = out_flush_reg;
    assign running            = out_run_reg;
    assign timer_armed        = out_armed_reg;
    assign min_report_latency = out_least_reg;
    assign any_live           = out_live_reg;
    assign overflow_drop      = out_drop_reg;

    a_armed_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
        armed_reg |-> run_reg)
        else $error("countdown armed while stopped");

    a_empty_least_ones: assert property (@(posedge clk) disable iff (!rst_n)
        !any_live_reg |-> (least_reg == LAT_ONES))
        else $error("empty table with a finite least latency");

    a_live_least_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        any_live_reg |-> (least_reg != '0))
        else $error("live table with zero least latency");

    a_flush_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
        flush_item_reg |-> (op_reg == bltf_pkg::OP_TICK))
        else $error("flush raised by a non-tick transaction");

    a_drop_stops: assert property (@(posedge clk) disable iff (!rst_n)
        drop_item_reg |-> (!run_reg && !armed_reg))
        else $error("overflow left the block running");

endmodule

### sim/tb_batch_latency_table_flush_timer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_batch_latency_table_flush_timer
// Self-checking bench for the sensor latency table and flush countdown.
// A directed walk covers reset status, control on an empty table, latency
// extremes, suspend and resume, clearing and id zero; random traffic then
// fills, overflows and drains the table under three idle profiles. Every
// result is checked field by field against a typed status or a bench model.
// ----------------------------------------------------------------------------
module tb_batch_latency_table_flush_timer;

    // Opcodes the block must treat as no-ops
    localparam logic [bltf_pkg::OPCODE_BITS-1:0] OP_RSVD_A = 3'd6;
    localparam logic [bltf_pkg::OPCODE_BITS-1:0] OP_RSVD_B = 3'd7;

    localparam logic [bltf_pkg::LATENCY_BITS-1:0] LAT_ONES = {bltf_pkg::LATENCY_BITS{1'b1}};

    localparam int QUIET_LIMIT  = 2000;   // cycles with no transaction on either side
    localparam int LONG_HOLD    = 300;    // receiver hold-off, in cycles
    localparam int DRAIN_CYCLES = 60;     // settle time after the last result
    localparam int RAND_PER_PHASE = 200;

    typedef struct packed {
        logic                              flush;
        logic                              running;
        logic                              armed;
        logic [bltf_pkg::LATENCY_BITS-1:0] min_lat;
        logic                              live;
        logic                              drop;
    } status_t;

    typedef struct packed {
        logic [bltf_pkg::OPCODE_BITS-1:0]  op;
        logic [bltf_pkg::SENSOR_BITS-1:0]  id;
        logic [bltf_pkg::LATENCY_BITS-1:0] lat;
        logic                              typed;  // 1: use the hand-written status below
        status_t                           want;
    } dir_row_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    logic [bltf_pkg::OPCODE_BITS-1:0]    opcode = '0;
    logic [bltf_pkg::SENSOR_BITS-1:0]    sensor_id = '0;
    logic [bltf_pkg::LATENCY_BITS-1:0]   latency = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic                                flush;
    logic                                running;
    logic                                timer_armed;
    logic [bltf_pkg::LATENCY_BITS-1:0]   min_report_latency;
    logic                                any_live;
    logic                                overflow_drop;

    // Model of the block: sensor slots, least latency, run/arm flags, countdown
    logic [bltf_pkg::SENSOR_BITS-1:0]    slot_id  [bltf_pkg::TABLE_ENTRIES];
    logic [bltf_pkg::LATENCY_BITS-1:0]   slot_lat [bltf_pkg::TABLE_ENTRIES];
    logic [bltf_pkg::LATENCY_BITS-1:0]   least_lat = LAT_ONES;
    logic                                run_on = 1'b0;
    logic                                armed_on = 1'b0;
    logic [bltf_pkg::LATENCY_BITS-1:0]   countdown = '0;

    status_t                   pending_status[$];
    dir_row_t                  directed_rows[$];

    int                        send_idle_pct = 0;
    int                        recv_idle_pct = 0;
    int                        id_pool = 8;
    int                        mismatch_count = 0;
    int                        result_count = 0;
    int                        quiet_cycles = 0;
    bit                        hold_request = 1'b0;
    bit                        hold_served = 1'b0;
    int                        hold_left = 0;

    batch_latency_table_flush_timer uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .opcode             (opcode),
        .sensor_id          (sensor_id),
        .latency            (latency),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .flush              (flush),
        .running            (running),
        .timer_armed        (timer_armed),
        .min_report_latency (min_report_latency),
        .any_live           (any_live),
        .overflow_drop      (overflow_drop)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic status_t mk_status(logic f, logic r, logic a,
                                          logic [bltf_pkg::LATENCY_BITS-1:0] m,
                                          logic l, logic d);
        status_t s;
        s.flush   = f;
        s.running = r;
        s.armed   = a;
        s.min_lat = m;
        s.live    = l;
        s.drop    = d;
        return s;
    endfunction

    function automatic void add_row(logic [bltf_pkg::OPCODE_BITS-1:0] op,
                                    logic [bltf_pkg::SENSOR_BITS-1:0] id,
                                    logic [bltf_pkg::LATENCY_BITS-1:0] lat,
                                    logic typed, status_t want);
        dir_row_t r;
        r.op    = op;
        r.id    = id;
        r.lat   = lat;
        r.typed = typed;
        r.want  = want;
        directed_rows.push_back(r);
    endfunction

    task automatic note_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Advance the table model by one accepted transaction and return its status.
    task automatic predict_status(input logic [bltf_pkg::OPCODE_BITS-1:0] op,
                                  input logic [bltf_pkg::SENSOR_BITS-1:0] id,
                                  input logic [bltf_pkg::LATENCY_BITS-1:0] lat,
                                  output status_t s);
        int hit;
        int blank;
        bit live;
        logic [bltf_pkg::LATENCY_BITS-1:0] least;
        s = '0;
        case (op)
            bltf_pkg::OP_SET:
            begin
                hit = -1;
                blank = -1;
                for (int k = 0; k < bltf_pkg::TABLE_ENTRIES; k++)
                begin
                    if (slot_id[k] == '0)
                    begin
                        if (blank < 0)
                            blank = k;
                    end
                    else if (slot_id[k] == id)
                        hit = k;
                end
                if (hit < 0)
                    hit = blank;
                if (hit < 0)
                begin
                    // table full and id is new: drop, leave table alone, stop
                    s.drop   = 1'b1;
                    run_on   = 1'b0;
                    armed_on = 1'b0;
                end
                else
                begin
                    if (lat != '0)
                    begin
                        slot_id[hit]  = id;
                        slot_lat[hit] = lat;
                    end
                    else
                    begin
                        slot_id[hit]  = '0;
                        slot_lat[hit] = '0;
                    end
                    least = LAT_ONES;
                    live  = 1'b0;
                    for (int k = 0; k < bltf_pkg::TABLE_ENTRIES; k++)
                    begin
                        if (slot_id[k] != '0)
                        begin
                            live = 1'b1;
                            if (slot_lat[k] < least)
                                least = slot_lat[k];
                        end
                    end
                    least_lat = least;
                    if (!live)
                    begin
                        run_on   = 1'b0;
                        armed_on = 1'b0;
                    end
                    else
                    begin
                        run_on    = 1'b1;
                        armed_on  = 1'b1;
                        countdown = least_lat;
                    end
                end
            end
            bltf_pkg::OP_START:
            begin
                if (!run_on)
                begin
                    run_on    = 1'b1;
                    armed_on  = 1'b1;
                    countdown = least_lat;
                end
            end
            bltf_pkg::OP_STOP:
            begin
                if (run_on)
                begin
                    run_on   = 1'b0;
                    armed_on = 1'b0;
                end
            end
            bltf_pkg::OP_SUSPEND:
            begin
                if (run_on)
                    armed_on = 1'b0;
            end
            bltf_pkg::OP_RESUME:
            begin
                if (run_on)
                begin
                    armed_on  = 1'b1;
                    countdown = least_lat;
                end
            end
            bltf_pkg::OP_TICK:
            begin
                if (armed_on)
                begin
                    if (countdown <= 1)
                    begin
                        s.flush   = 1'b1;
                        countdown = least_lat;
                    end
                    else
                        countdown = countdown - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        live = 1'b0;
        for (int k = 0; k < bltf_pkg::TABLE_ENTRIES; k++)
            if (slot_id[k] != '0)
                live = 1'b1;
        s.running = run_on;
        s.armed   = armed_on;
        s.min_lat = least_lat;
        s.live    = live;
    endtask

    // Offer one transaction: idle at random first, then hold valid until taken.
    // Call at a falling edge; returns at the falling edge after acceptance.
    task automatic offer_request(input logic [bltf_pkg::OPCODE_BITS-1:0] op,
                                 input logic [bltf_pkg::SENSOR_BITS-1:0] id,
                                 input logic [bltf_pkg::LATENCY_BITS-1:0] lat,
                                 input logic typed, input status_t want);
        status_t s;
        logic [63:0] junk;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            // drive junk on the payload while idle
            junk      = {$urandom(), $urandom()};
            in_valid  = 1'b0;
            opcode    = junk[2:0];
            sensor_id = junk[63:32];
            latency   = junk[47:0];
            @(negedge clk);
        end
        in_valid  = 1'b1;
        opcode    = op;
        sensor_id = id;
        latency   = lat;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        predict_status(op, id, lat, s);
        pending_status.push_back(typed ? want : s);
        @(negedge clk);
    endtask

    task automatic pick_request(output logic [bltf_pkg::OPCODE_BITS-1:0] op,
                                output logic [bltf_pkg::SENSOR_BITS-1:0] id,
                                output logic [bltf_pkg::LATENCY_BITS-1:0] lat);
        int r;
        logic [63:0] wide;
        r = $urandom_range(0, 99);
        if (r < 40)
            op = bltf_pkg::OP_SET;
        else if (r < 75)
            op = bltf_pkg::OP_TICK;
        else if (r < 95)
        begin
            case ($urandom_range(0, 3))
                0:       op = bltf_pkg::OP_START;
                1:       op = bltf_pkg::OP_STOP;
                2:       op = bltf_pkg::OP_SUSPEND;
                default: op = bltf_pkg::OP_RESUME;
            endcase
        end
        else
            op = ($urandom_range(0, 1) != 0) ? OP_RSVD_A : OP_RSVD_B;

        r = $urandom_range(0, 99);
        if (r < 84)
            id = $urandom_range(1, id_pool);
        else if (r < 89)
            id = '0;
        else if (r < 97)
        begin
            case ($urandom_range(0, 3))
                0:       id = 32'hFFFF_FFFF;
                1:       id = 32'h8000_0000;
                2:       id = 32'hAAAA_AAAA;
                default: id = 32'h5555_5555;
            endcase
        end
        else
            id = $urandom();

        r = $urandom_range(0, 99);
        wide = {$urandom(), $urandom()};
        if (r < 65)
            lat = bltf_pkg::LATENCY_BITS'($urandom_range(1, 6));
        else if (r < 77)
            lat = '0;
        else if (r < 90)
            lat = wide[47:0];
        else if (r < 95)
            lat = LAT_ONES;
        else
            lat = {{(bltf_pkg::LATENCY_BITS-1){1'b0}}, 1'b1}
                  << $urandom_range(0, bltf_pkg::LATENCY_BITS-1);
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_request && !hold_served)
        begin
            hold_left   = LONG_HOLD;
            hold_served = 1'b1;
        end
        if (hold_left > 0)
        begin
            out_ready = 1'b0;
            hold_left--;
        end
        else
            out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Check each accepted result against the oldest expected status
    always @(posedge clk)
    begin
        status_t got;
        status_t exp;
        if (rst_n && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            got = mk_status(flush, running, timer_armed, min_report_latency,
                            any_live, overflow_drop);
            if (pending_status.size() == 0)
                note_mismatch($sformatf("result %0d arrived with nothing expected",
                                        result_count));
            else
            begin
                exp = pending_status.pop_front();
                if (got.flush !== exp.flush)
                    note_mismatch($sformatf("result %0d flush got %b want %b",
                                            result_count, got.flush, exp.flush));
                if (got.running !== exp.running)
                    note_mismatch($sformatf("result %0d running got %b want %b",
                                            result_count, got.running, exp.running));
                if (got.armed !== exp.armed)
                    note_mismatch($sformatf("result %0d timer_armed got %b want %b",
                                            result_count, got.armed, exp.armed));
                if (got.min_lat !== exp.min_lat)
                    note_mismatch($sformatf("result %0d min_report_latency got %h want %h",
                                            result_count, got.min_lat, exp.min_lat));
                if (got.live !== exp.live)
                    note_mismatch($sformatf("result %0d any_live got %b want %b",
                                            result_count, got.live, exp.live));
                if (got.drop !== exp.drop)
                    note_mismatch($sformatf("result %0d overflow_drop got %b want %b",
                                            result_count, got.drop, exp.drop));
            end
            result_count++;
        end
    end

    // Watchdog: end the run if neither channel moves a transaction for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid === 1'b1 && in_ready === 1'b1) ||
                (out_valid === 1'b1 && out_ready === 1'b1))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("simulation failed");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        logic [bltf_pkg::OPCODE_BITS-1:0]  op;
        logic [bltf_pkg::SENSOR_BITS-1:0]  id;
        logic [bltf_pkg::LATENCY_BITS-1:0] lat;
        logic [bltf_pkg::SENSOR_BITS-1:0]  live_ids[$];
        logic [bltf_pkg::SENSOR_BITS-1:0]  fill_base;
        int                                sent;
        int                                r;

        for (int k = 0; k < bltf_pkg::TABLE_ENTRIES; k++)
        begin
            slot_id[k]  = '0;
            slot_lat[k] = '0;
        end

        // Directed walk. Typed rows carry the status read straight off the spec.
        add_row(bltf_pkg::OP_TICK, 32'h0, 48'h0, 1'b1,
                mk_status(1'b0, 1'b0, 1'b0, LAT_ONES, 1'b0, 1'b0));
        add_row(bltf_pkg::OP_START, 32'h0, 48'h0, 1'b1,
                mk_status(1'b0, 1'b1, 1'b1, LAT_ONES, 1'b0, 1'b0));
        add_row(bltf_pkg::OP_START, 32'h0, 48'h0, 1'b1,
                mk_status(1'b0, 1'b1, 1'b1, LAT_ONES, 1'b0, 1'b0));
        add_row(bltf_pkg::OP_STOP, 32'h0, 48'h0, 1'b1,
                mk_status(1'b0, 1'b0, 1'b0, LAT_ONES, 1'b0, 1'b0));
        add_row(bltf_pkg::OP_SUSPEND, 32'h0, 48'h0, 1'b1,
                mk_status(1'b0, 1'b0, 1'b0, LAT_ONES, 1'b0, 1'b0));
        add_row(bltf_pkg::OP_RESUME, 32'h0, 48'h0, 1'b1,
                mk_status(1'b0, 1'b0, 1'b0, LAT_ONES, 1'b0, 1'b0));
        add_row(bltf_pkg::OP_SET, 32'hFFFF_FFFF, LAT_ONES, 1'b1,
                mk_status(1'b0, 1'b1, 1'b1, LAT_ONES, 1'b1, 1'b0));
        add_row(bltf_pkg::OP_SET, 32'h1, 48'h1, 1'b1,
                mk_status(1'b0, 1'b1, 1'b1, 48'h1, 1'b1, 1'b0));
        add_row(bltf_pkg::OP_TICK, 32'h0, 48'h0, 1'b1,
                mk_status(1'b1, 1'b1, 1'b1, 48'h1, 1'b1, 1'b0));
        add_row(bltf_pkg::OP_SUSPEND, 32'h0, 48'h0, 1'b1,
                mk_status(1'b0, 1'b1, 1'b0, 48'h1, 1'b1, 1'b0));
        add_row(bltf_pkg::OP_TICK, 32'h0, 48'h0, 1'b1,
                mk_status(1'b0, 1'b1, 1'b0, 48'h1, 1'b1, 1'b0));
        // a set while suspended re-arms
        add_row(bltf_pkg::OP_SET, 32'h2, 48'h3, 1'b1,
                mk_status(1'b0, 1'b1, 1'b1, 48'h1, 1'b1, 1'b0));
        add_row(bltf_pkg::OP_SET, 32'h1, 48'h0, 1'b1,
                mk_status(1'b0, 1'b1, 1'b1, 48'h3, 1'b1, 1'b0));
        add_row(bltf_pkg::OP_TICK,    32'h0, 48'h0, 1'b0, '0);
        add_row(bltf_pkg::OP_TICK,    32'h0, 48'h0, 1'b0, '0);
        add_row(bltf_pkg::OP_TICK,    32'h0, 48'h0, 1'b0, '0);
        // id zero lands in a free slot and never counts as live
        add_row(bltf_pkg::OP_SET,     32'h0, 48'h5, 1'b0, '0);
        add_row(OP_RSVD_A,  32'hAAAA_AAAA, 48'hAAAA_AAAA_AAAA, 1'b0, '0);
        add_row(OP_RSVD_B,  32'h5555_5555, 48'h5555_5555_5555, 1'b0, '0);
        add_row(bltf_pkg::OP_RESUME,  32'h0, 48'h0, 1'b0, '0);
        add_row(bltf_pkg::OP_STOP,    32'h0, 48'h0, 1'b0, '0);
        add_row(bltf_pkg::OP_SET,     32'h2, 48'h0, 1'b0, '0);
        // clearing the last live sensor stops the block
        add_row(bltf_pkg::OP_SET, 32'hFFFF_FFFF, 48'h0, 1'b1,
                mk_status(1'b0, 1'b0, 1'b0, LAT_ONES, 1'b0, 1'b0));
        add_row(bltf_pkg::OP_SET, 32'h8000_0000, 48'h0, 1'b0, '0);

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_idle_pct = 12;
        recv_idle_pct = 87;
        foreach (directed_rows[i])
            offer_request(directed_rows[i].op, directed_rows[i].id, directed_rows[i].lat,
                          directed_rows[i].typed, directed_rows[i].want);

        // Random traffic in three idle profiles
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 12;
                    recv_idle_pct = 87;
                end
                1:
                begin
                    send_idle_pct = 87;
                    recv_idle_pct = 12;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    // hold the receiver off while the sender keeps offering
                    hold_request = 1'b1;
                end
            endcase
            sent = 0;
            while (sent < RAND_PER_PHASE)
            begin
                r = $urandom_range(0, 99);
                if (r < 2)
                begin
                    // fill with fresh ids past the table size to force overflow
                    fill_base = 32'h1000 + $urandom_range(0, 255) * 32;
                    for (int k = 0; k < bltf_pkg::TABLE_ENTRIES + 2; k++)
                    begin
                        offer_request(bltf_pkg::OP_SET, fill_base + k,
                                      bltf_pkg::LATENCY_BITS'($urandom_range(1, 8)),
                                      1'b0, '0);
                        sent++;
                    end
                end
                else if (r < 4)
                begin
                    // drain: clear every live sensor, table ends empty and stopped
                    live_ids.delete();
                    for (int k = 0; k < bltf_pkg::TABLE_ENTRIES; k++)
                        if (slot_id[k] != '0)
                            live_ids.push_back(slot_id[k]);
                    live_ids.shuffle();
                    foreach (live_ids[k])
                    begin
                        offer_request(bltf_pkg::OP_SET, live_ids[k], '0, 1'b0, '0);
                        sent++;
                    end
                end
                else if (r < 6)
                    id_pool = $urandom_range(2, bltf_pkg::TABLE_ENTRIES + 6);
                else
                begin
                    pick_request(op, id, lat);
                    offer_request(op, id, lat, 1'b0, '0);
                    sent++;
                end
            end
        end
        in_valid = 1'b0;

        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### batch_latency_table_flush_timer.f
rtl/bltf_pkg.sv
rtl/bltf_ctrl.sv
rtl/bltf_datapath.sv
rtl/batch_latency_table_flush_timer.sv
sim/tb_batch_latency_table_flush_timer.sv
